FILE: src/b64d_pkg.sv
// Shared types, constants and the alphabet lookup for the Base64 stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64d_pkg;

	localparam int NUM_RES = 4;          // most results one character can cause
	localparam int CNT_W   = 3;          // holds 0..NUM_RES

	localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_DIG_0 = 8'h30;
	localparam logic [7:0] CH_DIG_9 = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [7:0] OFS_LOWER = 8'd26;
	localparam logic [7:0] OFS_DIGIT = 8'd52;
	localparam logic [5:0] SX_PLUS   = 6'd62;
	localparam logic [5:0] SX_SLASH  = 6'd63;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STAT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LEN     = 3'd1,
		ST_BADCHAR = 3'd2,
		ST_MISPAD  = 3'd3,
		ST_PADPART = 3'd4,
		ST_TRAIL   = 3'd5
	} status_t;

	typedef struct packed {
		logic [17:0] held;
		logic [1:0]  grp;
		logic [1:0]  pad;
		status_t     err;
	} dec_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		status_t    status;
		logic       end_flag;
	} result_t;

	typedef result_t [NUM_RES-1:0] res_vec_t;

	typedef struct packed {
		res_vec_t         res;
		logic [CNT_W-1:0] cnt;
	} bundle_t;

	// {hit, sextet}; hit is low for anything outside the alphabet
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [7:0] t;
		logic [6:0] r;
		t = 8'd0;
		r = 7'd0;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			t = c - CH_UP_A;
			r = {1'b1, t[5:0]};
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			t = c - CH_LO_A + OFS_LOWER;
			r = {1'b1, t[5:0]};
		end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
			t = c - CH_DIG_0 + OFS_DIGIT;
			r = {1'b1, t[5:0]};
		end else if (c == CH_PLUS) begin
			r = {1'b1, SX_PLUS};
		end else if (c == CH_SLASH) begin
			r = {1'b1, SX_SLASH};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/b64d_step.sv
// Per-character decode: next decoder state and the bundle of results it causes.
// Purely combinational; depends on b64d_pkg.
`default_nettype none

module b64d_step
	import b64d_pkg::*;
(
	input  wire logic [7:0] char_code,
	input  wire logic       char_valid,
	input  wire logic       last,
	input  wire dec_state_t cur,
	output dec_state_t      nxt,
	output bundle_t         bnd
);

	function automatic result_t mk_data(input logic [7:0] b);
		result_t r;
		r.kind      = KIND_DATA;
		r.data_byte = b;
		r.status    = ST_OK;
		r.end_flag  = 1'b0;
		return r;
	endfunction

	function automatic result_t mk_stat(input status_t s);
		result_t r;
		r.kind      = KIND_STAT;
		r.data_byte = 8'd0;
		r.status    = s;
		r.end_flag  = 1'b1;
		return r;
	endfunction

	logic [6:0]       sx;
	logic [23:0]      w;
	logic [1:0]       rem;
	status_t          s;
	logic [CNT_W-1:0] n;

	always_comb begin
		nxt = cur;
		bnd = '0;
		n   = '0;
		s   = ST_OK;
		rem = 2'd0;
		sx  = sextet_of(char_code);
		w   = {cur.held, sx[5:0]};

		if (char_valid && cur.err == ST_OK) begin
			if (char_code == CH_PAD) begin
				if (cur.pad >= 2'd2) begin
					nxt.err = ST_MISPAD;
				end else begin
					nxt.pad = cur.pad + 2'd1;
				end
			end else if (!sx[6]) begin
				nxt.err = ST_BADCHAR;
			end else if (cur.pad != 2'd0) begin
				nxt.err = ST_MISPAD;
			end else if (cur.grp == 2'd3) begin
				bnd.res[0] = mk_data(w[23:16]);
				bnd.res[1] = mk_data(w[15:8]);
				bnd.res[2] = mk_data(w[7:0]);
				n          = 3'd3;
				nxt.held   = '0;
				nxt.grp    = 2'd0;
			end else begin
				nxt.held = {cur.held[11:0], sx[5:0]};
				nxt.grp  = cur.grp + 2'd1;
			end
		end

		if (last) begin
			s   = nxt.err;
			rem = nxt.grp + nxt.pad;
			if (s == ST_OK) begin
				if (rem == 2'd1) begin
					s = ST_LEN;
				end else if (nxt.pad != 2'd0 && rem != 2'd0) begin
					s = ST_PADPART;
				end else if (nxt.grp == 2'd2 && nxt.held[3:0] != 4'd0) begin
					s = ST_TRAIL;
				end else if (nxt.grp == 2'd3 && nxt.held[1:0] != 2'd0) begin
					s = ST_TRAIL;
				end
			end
			// leftover bytes of a partial group; never together with a full group
			if (s == ST_OK) begin
				if (nxt.grp == 2'd2) begin
					bnd.res[0] = mk_data(nxt.held[11:4]);
					n          = 3'd1;
				end else if (nxt.grp == 2'd3) begin
					bnd.res[0] = mk_data(nxt.held[17:10]);
					bnd.res[1] = mk_data(nxt.held[9:2]);
					n          = 3'd2;
				end
			end
			bnd.res[n[1:0]] = mk_stat(s);
			n   = n + 3'd1;
			nxt = '0;
		end

		bnd.cnt = n;
	end

endmodule

`default_nettype wire

FILE: src/b64d_outq.sv
// Result register: holds one bundle of up to four results and shifts them out
// one word per cycle while the output is not stalled. Depends on b64d_pkg.
`default_nettype none

module b64d_outq
	import b64d_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire bundle_t bnd,
	input  wire logic    stall,
	output logic         valid,
	output result_t      head,
	output logic         free
);

	res_vec_t         res_q;
	logic [CNT_W-1:0] cnt_q;
	logic             take;

	assign valid = (cnt_q != '0);
	assign head  = res_q[0];
	assign take  = valid && !stall;
	// room next cycle: empty, or the final word leaves now
	assign free  = (cnt_q == '0) || (cnt_q == CNT_W'(1) && take);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= bnd.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bnd.res;
		end else if (take) begin
			for (int i = 0; i < NUM_RES - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_RES))
		else $error("result count out of range");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (free && bnd.cnt != '0))
		else $error("bundle loaded over pending results or empty");

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && head.end_flag) |-> cnt_q == CNT_W'(1))
		else $error("status word is not the last of its bundle");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !load && cnt_q > CNT_W'(1)) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("result count did not step down");

endmodule

`default_nettype wire

FILE: src/base64_strict_stream_decoder.sv
// Base64 strict stream decoder, top level: decoder state, step logic, result register.
// Depends on b64d_pkg, b64d_step, b64d_outq.
// The first result of an item appears in the cycle after the item is accepted.
// One character per cycle while in_stall is low; an item with results holds the result
// register until all of them have left, and characters that cause results wait for it to drain.
// Reset (arst_n low, asynchronous) clears the decoder state and empties the results.
`default_nettype none

module base64_strict_stream_decoder
	import b64d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       char_valid,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            kind,
	output logic [7:0]      data_byte,
	output logic [2:0]      status,
	output logic            end_flag
);

	dec_state_t st_q;
	dec_state_t st_nxt;
	bundle_t    bnd;
	result_t    head;
	logic       q_free;
	logic       accept;

	b64d_step u_step (
		.char_code  (char_code),
		.char_valid (char_valid),
		.last       (last),
		.cur        (st_q),
		.nxt        (st_nxt),
		.bnd        (bnd)
	);

	// only words that bring results need the result register
	assign in_stall = (bnd.cnt != '0) && !q_free;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	b64d_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept && bnd.cnt != '0),
		.bnd    (bnd),
		.stall  (out_stall),
		.valid  (out_valid),
		.head   (head),
		.free   (q_free)
	);

	assign kind      = head.kind;
	assign data_byte = head.data_byte;
	assign status    = head.status;
	assign end_flag  = head.end_flag;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Testbench for base64_strict_stream_decoder: directed and random Base64 texts.
// A local decoder model predicts every data byte and end status, a monitor checks them.
// Depends on b64d_pkg and the RTL under src/.
module tb
	import b64d_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       char_valid;
	logic       last;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic [7:0] data_byte;
	logic [2:0] status;
	logic       end_flag;

	base64_strict_stream_decoder dut (.*);

	// model of the decoder state
	logic [17:0] held_q;
	logic [1:0]  grp_q;
	logic [1:0]  pad_q;
	status_t     err_q;

	result_t decoded_q[$];   // bytes and end statuses still to come out
	int      mismatches = 0;
	bit      calm = 1'b0;    // no idling on either side while set

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	function automatic int sextet_value(input logic [7:0] c);
		if (c >= CH_UP_A && c <= CH_UP_Z)
			return int'(c) - int'(CH_UP_A);
		if (c >= CH_LO_A && c <= CH_LO_Z)
			return int'(c) - int'(CH_LO_A) + int'(OFS_LOWER);
		if (c >= CH_DIG_0 && c <= CH_DIG_9)
			return int'(c) - int'(CH_DIG_0) + int'(OFS_DIGIT);
		if (c == CH_PLUS)
			return int'(SX_PLUS);
		if (c == CH_SLASH)
			return int'(SX_SLASH);
		return -1;
	endfunction

	function automatic logic [7:0] alpha_char(input logic [5:0] v);
		if (v < 6'd26)
			return CH_UP_A + 8'(v);
		if (v < 6'd52)
			return CH_LO_A + 8'(v) - OFS_LOWER;
		if (v < 6'd62)
			return CH_DIG_0 + 8'(v) - OFS_DIGIT;
		return (v == SX_PLUS) ? CH_PLUS : CH_SLASH;
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		result_t r;
		r.kind      = KIND_DATA;
		r.data_byte = b;
		r.status    = ST_OK;
		r.end_flag  = 1'b0;
		decoded_q.push_back(r);
	endfunction

	function automatic void push_status(input status_t s);
		result_t r;
		r.kind      = KIND_STAT;
		r.data_byte = 8'd0;
		r.status    = s;
		r.end_flag  = 1'b1;
		decoded_q.push_back(r);
	endfunction

	function automatic void decoder_clear();
		held_q = '0;
		grp_q  = '0;
		pad_q  = '0;
		err_q  = ST_OK;
	endfunction

	// one accepted word through the decoder model
	function automatic void decode_step(input logic [7:0] c, input logic cv, input logic lst);
		int          v;
		logic [23:0] w;
		logic [1:0]  rem;
		status_t     st;
		if (cv && err_q == ST_OK) begin
			if (c == CH_PAD) begin
				if (pad_q == 2'd2)
					err_q = ST_MISPAD;
				else
					pad_q++;
			end else begin
				v = sextet_value(c);
				if (v < 0) begin
					err_q = ST_BADCHAR;
				end else if (pad_q != 2'd0) begin
					err_q = ST_MISPAD;
				end else if (grp_q == 2'd3) begin
					w = {held_q, v[5:0]};
					push_byte(w[23:16]);
					push_byte(w[15:8]);
					push_byte(w[7:0]);
					held_q = '0;
					grp_q  = '0;
				end else begin
					held_q = {held_q[11:0], v[5:0]};
					grp_q++;
				end
			end
		end
		if (lst) begin
			st  = err_q;
			rem = grp_q + pad_q;
			if (st == ST_OK) begin
				if (rem == 2'd1)
					st = ST_LEN;
				else if (pad_q != 2'd0 && rem != 2'd0)
					st = ST_PADPART;
				else if (grp_q == 2'd2 && held_q[3:0] != 4'd0)
					st = ST_TRAIL;
				else if (grp_q == 2'd3 && held_q[1:0] != 2'd0)
					st = ST_TRAIL;
			end
			if (st == ST_OK) begin
				if (grp_q == 2'd2) begin
					push_byte(held_q[11:4]);
				end else if (grp_q == 2'd3) begin
					push_byte(held_q[17:10]);
					push_byte(held_q[9:2]);
				end
			end
			push_status(st);
			decoder_clear();
		end
	endfunction

	// called and left at a falling edge
	task automatic send_item(input logic [7:0] c, input logic cv, input logic lst);
		while (!calm && $urandom_range(0, 99) < 35) begin
			in_valid   = 1'b0;
			char_code  = 8'($urandom);
			char_valid = 1'($urandom);
			last       = 1'($urandom);
			@(negedge clk);
		end
		in_valid   = 1'b1;
		char_code  = c;
		char_valid = cv;
		last       = lst;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		decode_step(c, cv, lst);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, i == s.len() - 1);
	endtask

	task automatic test_well_formed();
		send_item(8'h00, 1'b0, 1'b1);     // empty text
		send_text("TWFu");
		send_text("TQ==");
		send_text("Zz+/");
		send_item(8'hA5, 1'b0, 1'b0);     // idle word, ignored
		send_item(8'hFF, 1'b0, 1'b1);     // close after a full group
	endtask

	task automatic test_end_errors();
		send_text("A");                   // one char too many
		send_text("TQ=");                 // padded, length not a multiple of 4
		send_text("TR==");                // leftover bits nonzero
	endtask

	task automatic test_stream_errors();
		send_item(8'hFF, 1'b1, 1'b1);     // outside the alphabet
		send_text("=A");                  // data after padding
		send_text("T===");                // third pad
	endtask

	task automatic test_random_texts(input int n_chars, input bit no_idle);
		logic [7:0] txt[$];
		logic [5:0] sx;
		int         tail;
		int         k;
		bit         empty_close;
		calm = no_idle;
		k = 0;
		while (k < n_chars) begin
			txt.delete();
			repeat ($urandom_range(0, 3) * 4)
				txt.push_back(alpha_char(6'($urandom)));
			tail = $urandom_range(0, 2);
			if (tail != 0) begin
				repeat (tail)
					txt.push_back(alpha_char(6'($urandom)));
				sx = 6'($urandom);
				// usually clear the unused low bits so the tail decodes
				if ($urandom_range(0, 3) != 0)
					sx = (tail == 1) ? (sx & 6'h30) : (sx & 6'h3C);
				txt.push_back(alpha_char(sx));
				if ($urandom_range(0, 1) != 0)
					repeat (3 - tail)
						txt.push_back(CH_PAD);
			end
			if ($urandom_range(0, 99) < 30) begin
				case ($urandom_range(0, 3))
					0: begin
						if (txt.size() != 0)
							txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
						else
							txt.push_back(8'($urandom));
					end
					1: begin
						if (txt.size() != 0)
							void'(txt.pop_back());
					end
					2: begin
						repeat ($urandom_range(1, 3))
							txt.push_back(CH_PAD);
					end
					default: begin
						txt.insert($urandom_range(0, txt.size()), CH_PAD);
					end
				endcase
			end
			empty_close = (txt.size() == 0) || ($urandom_range(0, 3) == 0);
			foreach (txt[i]) begin
				if ($urandom_range(0, 99) < 5)
					send_item(8'($urandom), 1'b0, 1'b0);
				send_item(txt[i], 1'b1, !empty_close && i == txt.size() - 1);
			end
			if (empty_close)
				send_item(8'($urandom), 1'b0, 1'b1);
			k += txt.size() + int'(empty_close);
		end
		calm = 1'b0;
	endtask

	always @(negedge clk)
		out_stall = calm ? 1'b0 : ($urandom_range(0, 99) < 35);

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word: kind %0d byte %02h status %0d end %0d",
					kind, data_byte, status, end_flag));
			end else begin
				want = decoded_q.pop_front();
				if (kind !== want.kind || data_byte !== want.data_byte ||
						status !== want.status || end_flag !== want.end_flag)
					report_mismatch($sformatf(
						"got kind %0d byte %02h status %0d end %0d, want %0d %02h %0d %0d",
						kind, data_byte, status, end_flag, want.kind, want.data_byte,
						want.status, want.end_flag));
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		char_code  = 8'd0;
		char_valid = 1'b0;
		last       = 1'b0;
		decoder_clear();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_well_formed();
		test_end_errors();
		test_stream_errors();
		test_random_texts(190, 1'b0);
		test_random_texts(80, 1'b1);
		test_random_texts(90, 1'b0);

		in_valid = 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
